// ===== rtl/sbsi_pkg.sv =====
// Package for the segment versus box slab test.
// Holds default widths and the axis count; no dependencies.
package sbsi_pkg;

  localparam int COORD_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int NUM_AXES          = 3;
  // Two divider lanes per axis: entry fraction and exit fraction.
  localparam int NUM_LANES         = 2 * NUM_AXES;

endpackage

// ===== rtl/segment_box_slab_intersect_top.sv =====
// Segment versus axis-aligned box intersection, slab method, fully pipelined.
// Depends on sbsi_pkg for default widths and lane counts.
//
// One request enters per clock while the pipeline is not stalled. The
// six restoring dividers, one per slab face and axis, each resolve one
// quotient bit per pipeline stage. One front stage forms the differences
// and early rejects, and one back stage merges the three axis intervals.
// out_stall freezes the whole pipeline while out_valid is high; in_stall
// follows it.
module segment_box_slab_intersect_top #(
  parameter int COORD_BITS    = sbsi_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = sbsi_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_box_min_x,
  input  logic signed [COORD_BITS-1:0]  in_box_min_y,
  input  logic signed [COORD_BITS-1:0]  in_box_min_z,
  input  logic signed [COORD_BITS-1:0]  in_box_max_x,
  input  logic signed [COORD_BITS-1:0]  in_box_max_y,
  input  logic signed [COORD_BITS-1:0]  in_box_max_z,
  input  logic signed [COORD_BITS-1:0]  in_seg_start_x,
  input  logic signed [COORD_BITS-1:0]  in_seg_start_y,
  input  logic signed [COORD_BITS-1:0]  in_seg_start_z,
  input  logic signed [COORD_BITS-1:0]  in_seg_end_x,
  input  logic signed [COORD_BITS-1:0]  in_seg_end_y,
  input  logic signed [COORD_BITS-1:0]  in_seg_end_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [FRACTION_BITS:0]        out_entry_fraction
);

  localparam int DW = COORD_BITS + 1;
  localparam int QW = FRACTION_BITS + 1;
  localparam int NSTEP = QW;
  localparam int NA = sbsi_pkg::NUM_AXES;
  localparam int NL = sbsi_pkg::NUM_LANES;
  localparam logic [QW-1:0] FRAC_ONE = QW'(1) << FRACTION_BITS;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- front stage: differences and rejects
  logic signed [DW-1:0] bmin [NA];
  logic signed [DW-1:0] bmax [NA];
  logic signed [DW-1:0] sp   [NA];
  logic signed [DW-1:0] ep   [NA];

  assign bmin[0] = DW'(in_box_min_x);
  assign bmin[1] = DW'(in_box_min_y);
  assign bmin[2] = DW'(in_box_min_z);
  assign bmax[0] = DW'(in_box_max_x);
  assign bmax[1] = DW'(in_box_max_y);
  assign bmax[2] = DW'(in_box_max_z);
  assign sp[0]   = DW'(in_seg_start_x);
  assign sp[1]   = DW'(in_seg_start_y);
  assign sp[2]   = DW'(in_seg_start_z);
  assign ep[0]   = DW'(in_seg_end_x);
  assign ep[1]   = DW'(in_seg_end_y);
  assign ep[2]   = DW'(in_seg_end_z);

  logic [DW-1:0] p_num_nxt [NL];
  logic [DW-1:0] p_den_nxt [NL];
  logic [NL-1:0] p_need_nxt;
  logic          p_ok_nxt;

  always_comb begin
    logic fwd;
    logic rej;
    p_ok_nxt = 1'b1;
    for (int a = 0; a < NA; a++) begin
      fwd = sp[a] < ep[a];
      if (fwd) begin
        rej                   = (sp[a] > bmax[a]) || (ep[a] < bmin[a]);
        p_need_nxt[2*a]       = sp[a] < bmin[a];
        p_need_nxt[2*a+1]     = ep[a] > bmax[a];
        p_num_nxt[2*a]        = DW'(bmin[a] - sp[a]);
        p_num_nxt[2*a+1]      = DW'(bmax[a] - sp[a]);
        p_den_nxt[2*a]        = DW'(ep[a] - sp[a]);
      end else begin
        rej                   = (ep[a] > bmax[a]) || (sp[a] < bmin[a]);
        p_need_nxt[2*a]       = sp[a] > bmax[a];
        p_need_nxt[2*a+1]     = ep[a] < bmin[a];
        p_num_nxt[2*a]        = DW'(sp[a] - bmax[a]);
        p_num_nxt[2*a+1]      = DW'(sp[a] - bmin[a]);
        p_den_nxt[2*a]        = DW'(sp[a] - ep[a]);
      end
      p_den_nxt[2*a+1] = p_den_nxt[2*a];
      if (rej) begin
        p_ok_nxt = 1'b0;
      end
    end
  end

  logic          p_vld_r;
  logic          p_ok_r;
  logic [NL-1:0] p_need_r;
  logic [DW-1:0] p_num_r [NL];
  logic [DW-1:0] p_den_r [NL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ok_r   <= p_ok_nxt;
      p_need_r <= p_need_nxt;
      p_num_r  <= p_num_nxt;
      p_den_r  <= p_den_nxt;
    end
  end

  // ---------------- divider stages: one quotient bit per stage
  logic          vld_r  [NSTEP];
  logic          ok_r   [NSTEP];
  logic [NL-1:0] need_r [NSTEP];
  logic [DW-1:0] rem_r  [NSTEP][NL];
  logic [DW-1:0] den_r  [NSTEP][NL];
  logic [QW-1:0] quo_r  [NSTEP][NL];

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic          vld_nxt;
    logic          ok_nxt;
    logic [NL-1:0] need_nxt;

    if (k == 0) begin : g_first
      assign vld_nxt  = p_vld_r;
      assign ok_nxt   = p_ok_r;
      assign need_nxt = p_need_r;
    end else begin : g_rest
      assign vld_nxt  = vld_r[k-1];
      assign ok_nxt   = ok_r[k-1];
      assign need_nxt = need_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ok_r[k]   <= ok_nxt;
        need_r[k] <= need_nxt;
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [DW:0]   trial;
      logic [DW-1:0] dsrc;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_nxt;
      logic [QW-1:0] quo_nxt;

      if (k == 0) begin : g_first
        assign trial   = {1'b0, p_num_r[l]};
        assign dsrc    = p_den_r[l];
        assign quo_nxt = QW'(ge);
      end else begin : g_rest
        assign trial   = {rem_r[k-1][l], 1'b0};
        assign dsrc    = den_r[k-1][l];
        assign quo_nxt = {quo_r[k-1][l][QW-2:0], ge};
      end

      assign diff    = trial - {1'b0, dsrc};
      assign ge      = trial >= {1'b0, dsrc};
      assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= rem_nxt;
          den_r[k][l] <= dsrc;
          quo_r[k][l] <= quo_nxt;
        end
      end
    end
  end

  // ---------------- merge stage: narrow the interval over all axes
  logic          hit_nxt;
  logic [QW-1:0] frac_nxt;

  always_comb begin
    logic [QW-1:0] lo;
    logic [QW-1:0] hi;
    logic [QW-1:0] st;
    logic [QW-1:0] et;
    lo = '0;
    hi = FRAC_ONE;
    for (int a = 0; a < NA; a++) begin
      st = need_r[NSTEP-1][2*a]   ? quo_r[NSTEP-1][2*a]   : '0;
      et = need_r[NSTEP-1][2*a+1] ? quo_r[NSTEP-1][2*a+1] : FRAC_ONE;
      if (st > lo) begin
        lo = st;
      end
      if (et < hi) begin
        hi = et;
      end
    end
    hit_nxt  = ok_r[NSTEP-1] && (hi >= lo);
    frac_nxt = hit_nxt ? lo : '0;
  end

  logic          out_valid_r;
  logic          out_hit_r;
  logic [QW-1:0] out_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[NSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r  <= hit_nxt;
      out_frac_r <= frac_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_entry_fraction = out_frac_r;

endmodule

// ===== test/tb.sv =====
// Testbench for segment_box_slab_intersect_top: slab test of a segment against a box.
// Depends on sbsi_pkg and the block's RTL; predicts each result and checks it in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = sbsi_pkg::COORD_BITS_DEF;
  localparam int FB = sbsi_pkg::FRACTION_BITS_DEF;

  typedef struct {
    logic signed [CB-1:0] bmin[3];
    logic signed [CB-1:0] bmax[3];
    logic signed [CB-1:0] ps[3];
    logic signed [CB-1:0] pe[3];
  } seg_box_t;

  typedef struct {
    bit         hit;
    bit [FB:0]  frac;
  } slab_result_t;

  // Truncating num * 2^FB / den, 0 <= num <= den.
  function automatic longint unsigned div_fraction(longint unsigned num,
                                                   longint unsigned den);
    if (den == 0) return 0;
    return (num << FB) / den;
  endfunction

  function automatic slab_result_t slab_intersect(seg_box_t r);
    longint lo, hi, st, et, bn, bx, s, e, d;
    slab_result_t res;
    lo = 0; hi = 1 << FB; res.hit = 1;
    for (int a = 0; a < 3; a++) begin
      if (res.hit) begin
        bn = r.bmin[a]; bx = r.bmax[a]; s = r.ps[a]; e = r.pe[a];
        st = 0; et = 1 << FB;
        d = (e > s) ? e - s : s - e;
        if (s < e) begin
          if (s > bx || e < bn) res.hit = 0;
          else begin
            if (s < bn) st = div_fraction(bn - s, d);
            if (e > bx) et = div_fraction(bx - s, d);
          end
        end else begin
          if (e > bx || s < bn) res.hit = 0;
          else begin
            if (s > bx) st = div_fraction(s - bx, d);
            if (e < bn) et = div_fraction(s - bn, d);
          end
        end
        if (res.hit) begin
          if (st > lo) lo = st;
          if (et < hi) hi = et;
          if (hi < lo) res.hit = 0;
        end
      end
    end
    res.frac = res.hit ? lo[FB:0] : '0;
    return res;
  endfunction

  class slab_scoreboard;
    slab_result_t pending[$];
    int errors, checked, hits;
    function void note_request(seg_box_t r);
      pending.push_back(slab_intersect(r));
    endfunction
    function void check_result(bit hit, bit [FB:0] frac);
      slab_result_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0d frac=%0d", $time, hit, frac);
        errors++;
        return;
      end
      x = pending.pop_front();
      checked++;
      if (x.hit) hits++;
      if (x.hit !== hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, x.hit, hit);
        errors++;
      end
      if (x.frac !== frac) begin
        $display("%0t: entry_fraction expected %0d actual %0d", $time, x.frac, frac);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid, out_hit;
  logic [FB:0] out_entry_fraction;
  logic signed [CB-1:0] bmin[3], bmax[3], ps[3], pe[3];
  slab_scoreboard sb = new();
  bit stim_done = 0, hold_long = 0;

  initial for (int a = 0; a < 3; a++) begin
    bmin[a] = 0; bmax[a] = 0; ps[a] = 0; pe[a] = 0;
  end

  always #5 clk = ~clk;

  segment_box_slab_intersect_top DUT (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_box_min_x(bmin[0]), .in_box_min_y(bmin[1]), .in_box_min_z(bmin[2]),
    .in_box_max_x(bmax[0]), .in_box_max_y(bmax[1]), .in_box_max_z(bmax[2]),
    .in_seg_start_x(ps[0]), .in_seg_start_y(ps[1]), .in_seg_start_z(ps[2]),
    .in_seg_end_x(pe[0]), .in_seg_end_y(pe[1]), .in_seg_end_z(pe[2]),
    .out_valid, .out_stall, .out_hit, .out_entry_fraction
  );

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_hit, out_entry_fraction);

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_long) begin
        out_stall <= 1;
        repeat (60) @(posedge clk);
        hold_long = 0;
      end
      n = gap_len();
      out_stall <= (n != 0);
      repeat (n == 0 ? $urandom_range(1, 12) : n) @(posedge clk);
    end
  end

  task automatic send_request(seg_box_t r);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    for (int a = 0; a < 3; a++) begin
      bmin[a] <= r.bmin[a]; bmax[a] <= r.bmax[a];
      ps[a] <= r.ps[a]; pe[a] <= r.pe[a];
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  function automatic logic [CB-1:0] rnd_coord(int mode);
    case (mode)
      0: return CB'({$urandom, $urandom} >> (64 - CB));
      1: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      2: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
      default: return $signed($urandom_range(0, 64)) - 32;
    endcase
  endfunction

  function automatic seg_box_t rnd_request();
    seg_box_t r;
    int mode;
    logic [CB-1:0] t;
    mode = $urandom_range(0, 9);
    mode = (mode < 2) ? 0 : (mode < 8) ? 1 : (mode == 8) ? 2 : 3;
    for (int a = 0; a < 3; a++) begin
      r.bmin[a] = rnd_coord(mode); r.bmax[a] = rnd_coord(mode);
      r.ps[a] = rnd_coord(mode); r.pe[a] = rnd_coord(mode);
      if ($urandom_range(0, 9) != 0 && r.bmin[a] > r.bmax[a]) begin
        t = r.bmin[a]; r.bmin[a] = r.bmax[a]; r.bmax[a] = t;
      end
      if ($urandom_range(0, 14) == 0) r.pe[a] = r.ps[a];
      if ($urandom_range(0, 14) == 0) r.ps[a] = r.bmin[a];
      if ($urandom_range(0, 14) == 0) r.pe[a] = r.bmax[a];
    end
    return r;
  endfunction

  function automatic seg_box_t mk(logic signed [CB-1:0] lo, logic signed [CB-1:0] hi,
                                  logic signed [CB-1:0] s, logic signed [CB-1:0] e);
    seg_box_t r;
    for (int a = 0; a < 3; a++) begin
      r.bmin[a] = lo; r.bmax[a] = hi; r.ps[a] = s; r.pe[a] = e;
    end
    return r;
  endfunction

  initial begin
    seg_box_t r;
    logic signed [CB-1:0] mx, mn;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: crossing, full extremes, parallel in/out, touching, inverted, miss
    send_request(mk(-(1 << 16), 1 << 16, -(4 << 16), 4 << 16));
    send_request(mk(mn, mx, mn, mx));
    send_request(mk(mn, mx, mx, mn));
    send_request(mk(0, 0, mn, mx));
    send_request(mk(mx, mx, mn, mx));
    send_request(mk(mn, mn, mx, mn));
    send_request(mk(0, 1 << 16, 5, 5));
    send_request(mk(0, 1 << 16, -5, -5));
    send_request(mk(0, 1 << 16, 1 << 16, 2 << 16));
    send_request(mk(0, 1 << 16, -(1 << 16), 0));
    send_request(mk(1 << 16, 0, -(4 << 16), 4 << 16));
    send_request(mk(2 << 16, 3 << 16, 0, 1 << 16));
    send_request(mk(0, 1 << 16, 3 << 16, -(2 << 16)));
    r = mk(0, 1 << 16, -(1 << 16), 2 << 16);
    r.ps[1] = 0; r.pe[1] = 3 << 16;   // x and y intervals that just touch
    r.bmin[1] = 2 << 16; r.bmax[1] = 3 << 16;
    send_request(r);
    send_request(mk(-1, 1, -3, 3));
    send_request(mk(mx, mn, 0, 0));
    for (int i = 0; i < 1900; i++) begin
      if (i == 600) hold_long = 1;
      send_request(rnd_request());
    end
    in_valid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (FB + 10) @(posedge clk);
    $display("Checked %0d results, %0d hits, across extreme, parallel, touching,",
             sb.checked, sb.hits);
    $display("inverted and random boxes with stalls on both sides.");
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end
endmodule
